FILE: hw/rtl/stfal_pkg.sv
// Shared constants and transaction types for the first-at-least max segment tree.
package stfal_pkg;

    localparam int LEAVES     = 1024;
    localparam int LEAF_BITS  = $clog2(LEAVES);
    localparam int PAD_LEAVES = 1 << LEAF_BITS;
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int NODES      = 2 * PAD_LEAVES;
    localparam int POS_W      = 11;
    localparam int VAL_W      = 32;

    typedef logic [NODE_BITS-1:0]    t_node;
    typedef logic signed [VAL_W-1:0] t_value;

    localparam t_value EMPTY = -32'sd2147483647;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] position;
        t_value           value;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] found_position;
    } t_out_item;

endpackage

FILE: hw/rtl/stfal_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stfal_ram #(
    parameter int DEPTH  = 2048,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/stfal_cmp.sv
// Shared signed compare and maximum unit used by both updates and searches.
module stfal_cmp (
    input  stfal_pkg::t_value i_a,
    input  stfal_pkg::t_value i_b,
    output logic              o_ge,
    output stfal_pkg::t_value o_max
);
    import stfal_pkg::*;

    assign o_ge  = (i_a >= i_b);
    assign o_max = o_ge ? i_a : i_b;
endmodule

FILE: hw/rtl/segment_tree_first_at_least.sv
// Top level of the max segment tree with its node sequencer.
//
// Input channel: i_in_valid, o_in_stall and i_in_item. A transaction either
// writes a value to a one-based position or searches for the first position at
// or after the given one whose element is at least the given value. Writes
// outside 1..LEAVES are dropped; they and all valid writes give no result.
// Output channel: o_out_valid, i_out_stall and o_out_item carry one result per
// search, with found_position zero when nothing qualifies.
// The tree sits in one RAM with one write and one registered read port, and
// one shared compare unit. A write stores the leaf and then each ancestor up to
// the root, one tree level per step. A search checks the start leaf, climbs
// through sibling checks, descends a level per step, then loads the result.
// One transaction is processed at a time and o_in_stall is high while it runs.
// After reset a clearing pass writes the empty marker to every node with
// o_in_stall high. A finished result waits in the output register while
// i_out_stall is high; a new write is taken meanwhile, and a following search
// holds in its last step until the register frees.
module segment_tree_first_at_least (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  stfal_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output stfal_pkg::t_out_item o_out_item
);
    import stfal_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_SIB, S_CLIMB, S_DOWN, S_DONE
    } t_state;

    t_state    r_state, n_state;
    t_node     r_clr, n_clr;
    t_node     r_node, n_node;
    t_value    r_val, n_val;
    logic      r_hit, n_hit;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic      mem_we;
    t_node     mem_waddr;
    t_value    mem_wdata;
    t_node     mem_raddr;
    t_value    mem_rdata;
    logic      cmp_ge;
    t_value    cmp_max;

    t_node     in_leaf;
    logic      in_ok;
    logic      is_leaf;
    t_node     parent;
    t_node     child_base;
    logic [LEAF_BITS-1:0] hit_idx;
    logic      hit_ok;

    stfal_ram #(
        .DEPTH (NODES),
        .WIDTH (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    stfal_cmp u_cmp (
        .i_a   (mem_rdata),
        .i_b   (r_val),
        .o_ge  (cmp_ge),
        .o_max (cmp_max)
    );

    assign in_leaf = t_node'(PAD_LEAVES) + t_node'(i_in_item.position) - t_node'(1);
    assign in_ok   = (i_in_item.position != '0) && (32'(i_in_item.position) <= LEAVES);
    assign is_leaf = r_node[NODE_BITS-1];
    assign parent  = r_node >> 1;
    assign child_base = cmp_ge ? r_node : (r_node | t_node'(1));
    assign hit_idx = r_node[LEAF_BITS-1:0];
    assign hit_ok  = r_hit && (32'(hit_idx) < LEAVES);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_val       = r_val;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = r_val;
        mem_raddr   = r_node;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = EMPTY;
                n_clr     = r_clr + t_node'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val = i_in_item.value;
                    if (i_in_item.action == ACT_WRITE) begin
                        if (in_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = in_leaf;
                            mem_wdata = i_in_item.value;
                            mem_raddr = in_leaf ^ t_node'(1);
                            n_node    = in_leaf;
                            n_state   = S_WRITE;
                        end
                    end else if (in_ok) begin
                        mem_raddr = in_leaf;
                        n_node    = in_leaf;
                        n_state   = S_SIB;
                    end else begin
                        n_hit   = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = cmp_max;
                mem_raddr = parent ^ t_node'(1);
                n_val     = cmp_max;
                n_node    = parent;
                if (parent == t_node'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SIB: begin
                if (cmp_ge) begin
                    if (is_leaf) begin
                        n_hit   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_node    = {r_node[NODE_BITS-2:0], 1'b0};
                        mem_raddr = {r_node[NODE_BITS-2:0], 1'b0};
                        n_state   = S_DOWN;
                    end
                end else begin
                    n_state = S_CLIMB;
                end
            end
            S_CLIMB: begin
                if (r_node == t_node'(1)) begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else if (!r_node[0]) begin
                    n_node    = r_node | t_node'(1);
                    mem_raddr = r_node | t_node'(1);
                    n_state   = S_SIB;
                end else begin
                    n_node = parent;
                end
            end
            S_DOWN: begin
                if (is_leaf) begin
                    n_hit   = 1'b1;
                    n_node  = child_base;
                    n_state = S_DONE;
                end else begin
                    n_node    = {child_base[NODE_BITS-2:0], 1'b0};
                    mem_raddr = {child_base[NODE_BITS-2:0], 1'b0};
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.found          = hit_ok;
                    n_out.found_position = hit_ok ? (POS_W'(hit_idx) + POS_W'(1)) : '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_node      <= n_node;
            r_val       <= n_val;
            r_hit       <= n_hit;
            r_out       <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

FILE: bench/stfal_checker.sv
// Checker that tracks element writes, predicts first-at-least search results and compares them.
`timescale 1ns / 100ps

module stfal_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  stfal_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  stfal_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);
    import stfal_pkg::*;

    t_value    element_store [1:LEAVES];
    t_out_item search_answers [$];

    function automatic t_out_item first_at_least(input logic [POS_W-1:0] start,
                                                 input t_value threshold);
        t_out_item answer;
        int        p;
        answer = '0;
        if (start != 0 && start <= LEAVES) begin
            for (p = int'(start); p <= LEAVES && !answer.found; p++) begin
                if (element_store[p] >= threshold) begin
                    answer.found          = 1'b1;
                    answer.found_position = POS_W'(p);
                end
            end
        end
        return answer;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        for (int p = 1; p <= LEAVES; p++) begin
            element_store[p] = EMPTY;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (search_answers.size() == 0) begin
                    $error("unexpected result: found %0d, found_position %0d",
                           i_out_item.found, i_out_item.found_position);
                    o_fail_count++;
                end else begin
                    want = search_answers.pop_front();
                    if (i_out_item.found !== want.found) begin
                        $error("found: expected %0d, actual %0d",
                               want.found, i_out_item.found);
                        o_fail_count++;
                    end
                    if (i_out_item.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, actual %0d",
                               want.found_position, i_out_item.found_position);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.action == ACT_QUERY) begin
                    search_answers = {search_answers,
                                      first_at_least(i_in_item.position, i_in_item.value)};
                end else if (i_in_item.position != 0 && i_in_item.position <= LEAVES) begin
                    element_store[i_in_item.position] = i_in_item.value;
                end
            end
            o_pending = search_answers.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top that drives writes and searches into the segment tree and gives the verdict.
`timescale 1ns / 100ps

module tb_top;
    import stfal_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        cycle_count;
    bit        gap_free  = 1'b0;

    segment_tree_first_at_least DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    stfal_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("segment_tree_first_at_least verification failed");
        $finish;
    end

    function automatic t_in_item make_item(input logic act, input int pos, input t_value val);
        t_in_item item;
        item.action   = act;
        item.position = POS_W'(pos);
        item.value    = val;
        return item;
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0:       return EMPTY;
            1:       return t_value'(32'h8000_0000);
            2:       return t_value'(32'h7fff_ffff);
            3:       return EMPTY + 1;
            4, 5:    return t_value'($urandom());
            default: return t_value'($urandom_range(0, 100)) - 50;
        endcase
    endfunction

    task automatic push_item(input t_in_item item);
        int gap;
        gap = gap_free ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin
        int stall_cycles;
        forever begin
            stall_cycles = gap_free ? 0 : $urandom_range(0, 9);
            if (stall_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int       span;
        int       window_lo;
        int       pos;
        int       taken;
        logic     act;
        t_in_item item;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Searches on the empty tree, out-of-range starts and dropped writes, then edge-value writes and searches.
        push_item(make_item(ACT_QUERY, 1, EMPTY));
        push_item(make_item(ACT_QUERY, 1, EMPTY + 1));
        push_item(make_item(ACT_QUERY, 0, EMPTY));
        push_item(make_item(ACT_QUERY, LEAVES + 1, EMPTY));
        push_item(make_item(ACT_QUERY, 2047, t_value'(32'h8000_0000)));
        push_item(make_item(ACT_WRITE, 0, 32'sd7));
        push_item(make_item(ACT_WRITE, LEAVES + 1, 32'sd7));
        push_item(make_item(ACT_WRITE, 2047, 32'sd7));
        push_item(make_item(ACT_QUERY, 1, 32'sd7));
        push_item(make_item(ACT_WRITE, 1, 32'sd5));
        push_item(make_item(ACT_WRITE, LEAVES, t_value'(32'h7fff_ffff)));
        push_item(make_item(ACT_WRITE, 512, t_value'(32'h8000_0000)));
        push_item(make_item(ACT_WRITE, 513, 32'sd0));
        push_item(make_item(ACT_QUERY, 1, 32'sd5));
        push_item(make_item(ACT_QUERY, 2, 32'sd5));
        push_item(make_item(ACT_QUERY, 2, 32'sd6));
        push_item(make_item(ACT_QUERY, LEAVES, t_value'(32'h7fff_ffff)));
        push_item(make_item(ACT_QUERY, 1, t_value'(32'h7fff_ffff)));
        push_item(make_item(ACT_QUERY, 512, t_value'(32'h8000_0000)));
        push_item(make_item(ACT_QUERY, 512, EMPTY));
        push_item(make_item(ACT_QUERY, 513, EMPTY + 1));
        push_item(make_item(ACT_QUERY, 514, -32'sd1));
        push_item(make_item(ACT_WRITE, 1, EMPTY));
        push_item(make_item(ACT_QUERY, 1, EMPTY));

        for (int phase = 0; phase < 11; phase++) begin
            gap_free = (phase % 4 == 1);
            case (phase % 3)
                0:       span = 16;
                1:       span = 128;
                default: span = LEAVES;
            endcase
            window_lo = $urandom_range(1, LEAVES - span + 1);
            taken = 0;
            while (taken < 100) begin
                act = ($urandom_range(0, 1) == 1) ? ACT_QUERY : ACT_WRITE;
                case ($urandom_range(0, 19))
                    0:       pos = 0;
                    1:       pos = $urandom_range(LEAVES + 1, 2047);
                    2:       pos = $urandom_range(1, LEAVES);
                    default: pos = $urandom_range(window_lo, window_lo + span - 1);
                endcase
                item = make_item(act, pos, pick_value());
                push_item(item);
                if (act == ACT_QUERY || (pos >= 1 && pos <= LEAVES)) begin
                    taken++;
                end
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("segment_tree_first_at_least verification clean");
        end else begin
            $display("segment_tree_first_at_least verification failed");
        end
        $finish;
    end

endmodule
